// File: rtl/pdd_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph decryptor.
package pdd_pkg;

	// Letter coding and key square geometry.
	localparam int unsigned NUM_LETTERS = 26;
	localparam int unsigned SQ_CELLS    = 25;
	localparam int unsigned SQ_SIDE     = 5;
	localparam logic [4:0]  LETTER_I    = 5'd8;
	localparam logic [4:0]  LETTER_J    = 5'd9;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] place_t;
	typedef logic [2:0] coord_t;

	// Operation codes carried by the op field.
	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_KEY     = 2'd1,
		OP_FINISH  = 2'd2,
		OP_DECRYPT = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_RDA,
		S_RDB,
		S_SQA,
		S_SQB,
		S_DONE
	} state_t;

	// Row of a cell index: p / 5 as (p * 13) >> 6, exact for p below 25.
	function automatic coord_t place_row(place_t p);
		logic [8:0] prod;
		prod = 9'(p) * 9'd13;
		return prod[8:6];
	endfunction

	// Column of a cell index: p - 5 * row.
	function automatic coord_t place_col(place_t p);
		coord_t     r;
		logic [4:0] five_r;
		logic [4:0] diff;
		r      = place_row(p);
		five_r = {r, 2'b00} + {2'b00, r};
		diff   = p - five_r;
		return diff[2:0];
	endfunction

	// Cell index from row and column.
	function automatic place_t cell_index(coord_t r, coord_t c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

// File: rtl/pdd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pdd_ram #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pdd_cell_step.sv
// Shared unit that maps one cipher letter's cell to its plaintext cell.
module pdd_cell_step
	import pdd_pkg::*;
(
	input  place_t self_place,
	input  place_t other_place,
	output place_t cell_idx
);

	coord_t rs;
	coord_t cs;
	coord_t ro;
	coord_t co;
	coord_t r_new;
	coord_t c_new;

	// Split both places into row and column.
	always_comb begin
		rs = place_row(self_place);
		cs = place_col(self_place);
		ro = place_row(other_place);
		co = place_col(other_place);
	end

	// Same row: step left. Same column: step up. Otherwise take the other column.
	always_comb begin
		r_new = rs;
		c_new = co;
		if (rs == ro) begin
			c_new = (cs == 3'd0) ? 3'(SQ_SIDE - 1) : cs - 3'd1;
		end else if (cs == co) begin
			r_new = (rs == 3'd0) ? 3'(SQ_SIDE - 1) : rs - 3'd1;
		end
	end

	assign cell_idx = cell_index(r_new, c_new);

endmodule

// File: rtl/playfair_digraph_decrypt.sv
// Top level of the Playfair digraph decryptor: key square build and pair decryption.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | op, letter_a, letter_b
//   output  | out       | out_valid/out_stall| plain_a, plain_b
//
// Clear and key-letter beats act in the cycle they are accepted. A finish beat makes
// the sequencer walk all 26 letters, one placement through the RAM write ports per cycle.
// A decrypt beat runs four single-read-port RAM reads in turn, two of them
// addressed by the shared cell-step unit, then the load of the output register.
// Reset clears the used marks, the fill count, the output valid and the sequencer; the RAMs are not cleared.
// The output register holds a result while out_stall is high; the block takes new
// input meanwhile and only waits before loading a second result.
module playfair_digraph_decrypt
	import pdd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic [1:0] op,
	input  letter_t letter_a,
	input  letter_t letter_b,
	output logic    out_valid,
	input  logic    out_stall,
	output letter_t plain_a,
	output letter_t plain_b
);

	state_t  state_q;
	state_t  state_d;
	logic [NUM_LETTERS-1:0] used_q;
	logic [4:0] fill_q;
	letter_t idx_q;
	letter_t a_q;
	letter_t b_q;
	place_t  pa_q;
	place_t  pb_q;
	letter_t oa_q;
	logic    out_valid_q;
	letter_t plain_a_q;
	letter_t plain_b_q;

	logic    in_acc;
	logic    out_acc;
	logic    out_load;
	logic    dec_ok;
	letter_t a_map;
	letter_t b_map;
	letter_t place_letter;
	logic    place_en;
	logic    place_ok;
	logic    sq_re;
	place_t  sq_raddr;
	letter_t sq_rdata;
	logic    pl_re;
	letter_t pl_raddr;
	place_t  pl_rdata;
	place_t  unit_self;
	place_t  unit_other;
	place_t  unit_cell;

	// Handshakes.
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign plain_a   = plain_a_q;
	assign plain_b   = plain_b_q;

	// A decrypt beat needs a full square and two letters in range; J reads as I.
	assign dec_ok = (fill_q == 5'(SQ_CELLS)) && (letter_a < 5'(NUM_LETTERS))
		&& (letter_b < 5'(NUM_LETTERS));
	assign a_map  = (letter_a == LETTER_J) ? LETTER_I : letter_a;
	assign b_map  = (letter_b == LETTER_J) ? LETTER_I : letter_b;

	// Letter placement, shared by key beats and the finish walk.
	assign place_letter = (state_q == S_FILL) ? idx_q : letter_a;
	assign place_en     = (in_acc && (op == OP_KEY)) || (state_q == S_FILL);
	assign place_ok     = place_en && (place_letter < 5'(NUM_LETTERS))
		&& (place_letter != LETTER_J) && !used_q[place_letter]
		&& (fill_q < 5'(SQ_CELLS));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (op == OP_FINISH)) begin
					state_d = S_FILL;
				end else if (in_acc && (op == OP_DECRYPT) && dec_ok) begin
					state_d = S_RDA;
				end
			end
			S_FILL: begin
				if (idx_q == 5'(NUM_LETTERS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_RDA:  state_d = S_RDB;
			S_RDB:  state_d = S_SQA;
			S_SQA:  state_d = S_SQB;
			S_SQB:  state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM read controls and shared unit operands.
	always_comb begin
		pl_re      = 1'b0;
		pl_raddr   = a_q;
		sq_re      = 1'b0;
		unit_self  = pa_q;
		unit_other = pl_rdata;
		case (state_q)
			S_RDA: begin
				pl_re    = 1'b1;
				pl_raddr = a_q;
			end
			S_RDB: begin
				pl_re    = 1'b1;
				pl_raddr = b_q;
			end
			S_SQA: begin
				sq_re      = 1'b1;
				unit_self  = pa_q;
				unit_other = pl_rdata;
			end
			S_SQB: begin
				sq_re      = 1'b1;
				unit_self  = pb_q;
				unit_other = pa_q;
			end
			default: begin
				pl_re = 1'b0;
				sq_re = 1'b0;
			end
		endcase
	end

	assign sq_raddr = unit_cell;

	pdd_cell_step u_cell_step (
		.self_place  (unit_self),
		.other_place (unit_other),
		.cell_idx    (unit_cell)
	);

	// Key square: cell index to letter.
	pdd_ram #(
		.WIDTH (5),
		.DEPTH (SQ_CELLS)
	) u_square_ram (
		.clk   (clk),
		.we    (place_ok),
		.waddr (fill_q),
		.wdata (place_letter),
		.re    (sq_re),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	// Letter place table: letter to cell index.
	pdd_ram #(
		.WIDTH (5),
		.DEPTH (NUM_LETTERS)
	) u_place_ram (
		.clk   (clk),
		.we    (place_ok),
		.waddr (place_letter),
		.wdata (fill_q),
		.re    (pl_re),
		.raddr (pl_raddr),
		.rdata (pl_rdata)
	);

	// Control state: sequencer, used marks, fill count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && (op == OP_CLEAR)) begin
				used_q <= '0;
				fill_q <= '0;
			end else if (place_ok) begin
				used_q[place_letter] <= 1'b1;
				fill_q               <= fill_q + 5'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the finish walk and the decrypt sequence.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q <= '0;
			a_q   <= a_map;
			b_q   <= b_map;
		end else if (state_q == S_FILL) begin
			idx_q <= idx_q + 5'd1;
		end
		if (state_q == S_RDB) begin
			pa_q <= pl_rdata;
		end
		if (state_q == S_SQA) begin
			pb_q <= pl_rdata;
		end
		if (state_q == S_SQB) begin
			oa_q <= sq_rdata;
		end
		if (out_load) begin
			plain_a_q <= oa_q;
			plain_b_q <= sq_rdata;
		end
	end

	// The fill count never passes the number of cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'(SQ_CELLS))
		else $error("fill count above square size");

	// The finish walk always leaves a full square.
	a_finish_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) && (idx_q == 5'(NUM_LETTERS - 1)) |=> fill_q == 5'(SQ_CELLS))
		else $error("square not full after finish");

	// A result appears only out of the last decrypt step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without decrypt sequence");

	// A decrypt sequence starts only with a full square.
	a_dec_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDA) |-> fill_q == 5'(SQ_CELLS))
		else $error("decrypt started on a partial square");

endmodule
